// ===== src/triple_key_vigenere_stream_defines.svh =====
// assertion macros used by the checker file
`ifndef TRIPLE_KEY_VIGENERE_STREAM_DEFINES_SVH
`define TRIPLE_KEY_VIGENERE_STREAM_DEFINES_SVH

// same-cycle implication, quiet while reset is low
`define TKV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is low
`define TKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers reset cycles
`define TKV_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tkv_pkg.sv =====
package tkv_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned ShiftWidth  = 5;
    localparam int unsigned SumWidth    = 7;
    localparam int unsigned Pos1Width   = 3;
    localparam int unsigned Pos2Width   = 4;
    localparam int unsigned Pos3Width   = 3;

    localparam logic [Pos1Width-1:0] Key1Last = Pos1Width'(7);
    localparam logic [Pos2Width-1:0] Key2Last = Pos2Width'(13);
    localparam logic [Pos3Width-1:0] Key3Last = Pos3Width'(5);

    localparam logic [SumWidth-1:0]  Alphabet  = SumWidth'(26);
    localparam logic [CharWidth-1:0] UpperBase = CharWidth'(65);
    localparam logic [CharWidth-1:0] LowerBase = CharWidth'(97);

    typedef logic [CharWidth-1:0]  t_char;
    typedef logic [ShiftWidth-1:0] t_shift;
    typedef logic [Pos1Width-1:0]  t_pos1;
    typedef logic [Pos2Width-1:0]  t_pos2;
    typedef logic [Pos3Width-1:0]  t_pos3;

    // VIGENERE
    function automatic t_shift key1_letter(input t_pos1 pos);
        t_shift v;
        case (pos)
            3'd0:    v = 5'd21;
            3'd1:    v = 5'd8;
            3'd2:    v = 5'd6;
            3'd3:    v = 5'd4;
            3'd4:    v = 5'd13;
            3'd5:    v = 5'd4;
            3'd6:    v = 5'd17;
            3'd7:    v = 5'd4;
            default: v = 5'd21;
        endcase
        return v;
    endfunction

    // POLYALPHABETIC
    function automatic t_shift key2_letter(input t_pos2 pos);
        t_shift v;
        case (pos)
            4'd0:    v = 5'd15;
            4'd1:    v = 5'd14;
            4'd2:    v = 5'd11;
            4'd3:    v = 5'd24;
            4'd4:    v = 5'd0;
            4'd5:    v = 5'd11;
            4'd6:    v = 5'd15;
            4'd7:    v = 5'd7;
            4'd8:    v = 5'd0;
            4'd9:    v = 5'd1;
            4'd10:   v = 5'd4;
            4'd11:   v = 5'd19;
            4'd12:   v = 5'd8;
            4'd13:   v = 5'd2;
            default: v = 5'd15;
        endcase
        return v;
    endfunction

    // CIPHER
    function automatic t_shift key3_letter(input t_pos3 pos);
        t_shift v;
        case (pos)
            3'd0:    v = 5'd2;
            3'd1:    v = 5'd8;
            3'd2:    v = 5'd15;
            3'd3:    v = 5'd7;
            3'd4:    v = 5'd4;
            3'd5:    v = 5'd17;
            default: v = 5'd2;
        endcase
        return v;
    endfunction

endpackage

// ===== src/triple_key_vigenere_stream.sv =====
// Byte stream cipher with three chained Vigenere keywords (VIGENERE, POLYALPHABETIC,
// CIPHER) folded into one shift per byte. Send bytes on s_axis with tuser high on the
// first byte of each message to restart the keywords; results leave on m_axis in order,
// one per input byte. Letters keep their case, every other byte passes unchanged but
// still advances the keywords. i_cfg_wr_data selects decrypt (1) or encrypt (0); write
// it only while the stream is empty. One byte is accepted every cycle while m_axis is not
// stalled; a byte passes from the input register to the result register and then onto
// m_axis, with the key lookup, mod-26 sum and letter shift between the two registers.
// Backpressure on m_axis holds the result register, and the input register once it is full.
module triple_key_vigenere_stream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tuser,   // [0] start_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] char_out
);

    logic               r_decrypt_mode;
    logic               r_in_valid;
    tkv_pkg::t_char     r_in_char;
    logic               r_in_start;
    logic               r_out_valid;
    tkv_pkg::t_char     r_out_char;
    tkv_pkg::t_pos1     r_pos1;
    tkv_pkg::t_pos2     r_pos2;
    tkv_pkg::t_pos3     r_pos3;

    tkv_pkg::t_pos1     n_pos1;
    tkv_pkg::t_pos2     n_pos2;
    tkv_pkg::t_pos3     n_pos3;
    tkv_pkg::t_char     n_out_char;

    tkv_pkg::t_pos1     cur_pos1;
    tkv_pkg::t_pos2     cur_pos2;
    tkv_pkg::t_pos3     cur_pos3;
    logic [tkv_pkg::SumWidth-1:0] key_sum;
    logic [tkv_pkg::SumWidth-1:0] sum_m1;
    logic [tkv_pkg::SumWidth-1:0] shift;
    logic [tkv_pkg::SumWidth-1:0] offset;
    logic [tkv_pkg::SumWidth-1:0] moved;
    tkv_pkg::t_char     base;
    logic               is_upper;
    logic               is_lower;
    logic               advance;
    logic               in_accept;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = i_rst_n && (!r_in_valid || advance);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;

    // key positions for the byte in the input register
    always_comb begin
        if (r_in_start) begin
            cur_pos1 = '0;
            cur_pos2 = '0;
            cur_pos3 = '0;
        end else begin
            cur_pos1 = r_pos1;
            cur_pos2 = (r_pos2 > tkv_pkg::Key2Last) ? '0 : r_pos2;
            cur_pos3 = (r_pos3 > tkv_pkg::Key3Last) ? '0 : r_pos3;
        end
        n_pos1 = (cur_pos1 == tkv_pkg::Key1Last) ? '0 : cur_pos1 + 1'b1;
        n_pos2 = (cur_pos2 == tkv_pkg::Key2Last) ? '0 : cur_pos2 + 1'b1;
        n_pos3 = (cur_pos3 == tkv_pkg::Key3Last) ? '0 : cur_pos3 + 1'b1;
    end

    // folded shift, sum is at most 62
    always_comb begin
        key_sum = tkv_pkg::SumWidth'(tkv_pkg::key1_letter(cur_pos1))
                + tkv_pkg::SumWidth'(tkv_pkg::key2_letter(cur_pos2))
                + tkv_pkg::SumWidth'(tkv_pkg::key3_letter(cur_pos3));
        sum_m1  = (key_sum >= tkv_pkg::Alphabet) ? key_sum - tkv_pkg::Alphabet : key_sum;
        shift   = (sum_m1 >= tkv_pkg::Alphabet) ? sum_m1 - tkv_pkg::Alphabet : sum_m1;
    end

    // letter shift within its own case
    always_comb begin
        is_upper = (r_in_char >= tkv_pkg::UpperBase)
                && (r_in_char < tkv_pkg::UpperBase + tkv_pkg::CharWidth'(tkv_pkg::Alphabet));
        is_lower = (r_in_char >= tkv_pkg::LowerBase)
                && (r_in_char < tkv_pkg::LowerBase + tkv_pkg::CharWidth'(tkv_pkg::Alphabet));
        base     = is_lower ? tkv_pkg::LowerBase : tkv_pkg::UpperBase;
        offset   = tkv_pkg::SumWidth'(r_in_char - base);
        if (r_decrypt_mode) begin
            moved = (offset >= shift) ? offset - shift : offset + tkv_pkg::Alphabet - shift;
        end else begin
            moved = offset + shift;
            if (moved >= tkv_pkg::Alphabet) begin
                moved = moved - tkv_pkg::Alphabet;
            end
        end
        if (is_upper || is_lower) begin
            n_out_char = base + tkv_pkg::CharWidth'(moved);
        end else begin
            n_out_char = r_in_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt_mode <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_pos1         <= '0;
            r_pos2         <= '0;
            r_pos3         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_decrypt_mode <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_pos1 <= n_pos1;
                    r_pos2 <= n_pos2;
                    r_pos3 <= n_pos3;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        if (advance && r_in_valid) begin
            r_out_char <= n_out_char;
        end
    end

endmodule

// ===== src/tkv_checker.sv =====
`include "triple_key_vigenere_stream_defines.svh"

module tkv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // reset empties the result register
    `TKV_ASSERT_ALWAYS_NEXT(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid, "valid after reset")

    // a stalled result holds its byte
    `TKV_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // every accepted byte has a result waiting once it has passed the input and result registers
    `TKV_ASSERT_NOW(a_accept_latency, i_clk, i_rst_n, in_accept, ##2 m_axis_tvalid, "result missing after transaction")

    // a fresh result always comes from a transaction that has passed the input and result registers
    `TKV_ASSERT_NOW(a_no_invented, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(in_accept, 2), "result without transaction")

endmodule

bind triple_key_vigenere_stream tkv_checker u_tkv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
